// ===== design/bhc_pkg.sv =====
// ----------------------------------------------------------------------------
// bhc_pkg
// Shared types, constants and the microcode table of the beat envelope and
// hue cycler.
// ----------------------------------------------------------------------------
package bhc_pkg;

   // Microprogram addressing.
   localparam int unsigned STEP_W = 4;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_IDLE = 4'd0;
   localparam step_type STEP_EMIT = 4'd11;
   localparam step_type STEP_DIV  = 4'd13;

   // Fixed constants of the color math.
   localparam logic [8:0] HUE_LAST    = 9'd359;
   localparam int unsigned SECTOR_SPAN = 60;
   localparam logic [7:0] FULL_SCALE  = 8'd255;

   // Register reset values.
   localparam logic [7:0] ATTACK_RESET  = 8'hF0;
   localparam logic [7:0] RELEASE_RESET = 8'd7;
   localparam logic [7:0] SAT_RESET     = 8'hFF;

   // Register indexes of the control port.
   localparam logic [1:0] CSR_ATTACK     = 2'd0;
   localparam logic [1:0] CSR_RELEASE    = 2'd1;
   localparam logic [1:0] CSR_SATURATION = 2'd2;

   // Datapath operation of one step.
   typedef enum logic [2:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_SECTOR,
      OP_FRAC,
      OP_EMIT,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_DECAY
   } op_type;

   // Operand pair fed to the shared multiplier.
   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_VS,   // brightness * (255 - saturation)
      MUL_SF,   // saturation * fraction
      MUL_SNF,  // saturation * (255 - fraction)
      MUL_VT    // brightness * (255 - scratch)
   } mul_sel_type;

   // Destination of the divide-by-255 of the product register.
   typedef enum logic [2:0] {
      DST_NONE,
      DST_P,
      DST_Q,
      DST_T,
      DST_TMP
   } dst_type;

   // Sequencing of one step.
   typedef enum logic [2:0] {
      JMP_NEXT,
      JMP_ALWAYS,
      JMP_NO_REQ,
      JMP_OUT_BUSY,
      JMP_DIV_MORE
   } jump_type;

   typedef struct packed {
      op_type      op;
      mul_sel_type mul;
      dst_type     dst;
      jump_type    jmp;
      step_type    target;
   } ucode_word_type;

   // Control from the sequencer to the datapath.
   typedef struct packed {
      ucode_word_type word;
      logic           go;
   } ctrl_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic div_last;
   } dp_status_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   // Microprogram. Wait steps jump to themselves until their condition holds.
   function automatic ucode_word_type ucode_rom(input step_type step);
      ucode_word_type w;
      unique case (step)
         4'd0:    w = '{OP_ACCEPT,   MUL_NONE, DST_NONE, JMP_NO_REQ,   STEP_IDLE};
         4'd1:    w = '{OP_SECTOR,   MUL_NONE, DST_NONE, JMP_NEXT,     STEP_IDLE};
         4'd2:    w = '{OP_FRAC,     MUL_NONE, DST_NONE, JMP_NEXT,     STEP_IDLE};
         4'd3:    w = '{OP_NOP,      MUL_VS,   DST_NONE, JMP_NEXT,     STEP_IDLE};
         4'd4:    w = '{OP_NOP,      MUL_SF,   DST_P,    JMP_NEXT,     STEP_IDLE};
         4'd5:    w = '{OP_NOP,      MUL_NONE, DST_TMP,  JMP_NEXT,     STEP_IDLE};
         4'd6:    w = '{OP_NOP,      MUL_VT,   DST_NONE, JMP_NEXT,     STEP_IDLE};
         4'd7:    w = '{OP_NOP,      MUL_SNF,  DST_Q,    JMP_NEXT,     STEP_IDLE};
         4'd8:    w = '{OP_NOP,      MUL_NONE, DST_TMP,  JMP_NEXT,     STEP_IDLE};
         4'd9:    w = '{OP_NOP,      MUL_VT,   DST_NONE, JMP_NEXT,     STEP_IDLE};
         4'd10:   w = '{OP_NOP,      MUL_NONE, DST_T,    JMP_NEXT,     STEP_IDLE};
         4'd11:   w = '{OP_EMIT,     MUL_NONE, DST_NONE, JMP_OUT_BUSY, STEP_EMIT};
         4'd12:   w = '{OP_DIV_INIT, MUL_NONE, DST_NONE, JMP_NEXT,     STEP_IDLE};
         4'd13:   w = '{OP_DIV_STEP, MUL_NONE, DST_NONE, JMP_DIV_MORE, STEP_DIV};
         4'd14:   w = '{OP_DECAY,    MUL_NONE, DST_NONE, JMP_ALWAYS,   STEP_IDLE};
         default: w = '{OP_NOP,      MUL_NONE, DST_NONE, JMP_ALWAYS,   STEP_IDLE};
      endcase
      return w;
   endfunction

   // Exact floor(x / 255) for any product of two bytes.
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] sum;
      sum = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
      return sum[15:8];
   endfunction

endpackage

// ===== design/bhc_seq.sv =====
// ----------------------------------------------------------------------------
// bhc_seq
// Step counter and microcode table; issues one control word per cycle.
// ----------------------------------------------------------------------------
module bhc_seq
   import bhc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          out_free,
   input  dp_status_type status,
   output ctrl_type      ctrl,
   output step_type      step
);

   step_type       step_ff;
   step_type       step_in;
   ucode_word_type word;
   logic           go;
   logic           taken;

   assign word = ucode_rom(step_ff);

   // A wait step holds off its datapath action until its condition is met.
   always_comb begin
      unique case (word.jmp)
         JMP_NO_REQ:   go = req_valid;
         JMP_OUT_BUSY: go = out_free;
         default:      go = 1'b1;
      endcase
   end

   // Jump decision.
   always_comb begin
      unique case (word.jmp)
         JMP_ALWAYS:   taken = 1'b1;
         JMP_NO_REQ:   taken = !req_valid;
         JMP_OUT_BUSY: taken = !out_free;
         JMP_DIV_MORE: taken = !status.div_last;
         default:      taken = 1'b0;
      endcase
   end

   // Next step address.
   always_comb begin
      if (taken) begin
         step_in = word.target;
      end else begin
         step_in = step_ff + step_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctrl.word = word;
   assign ctrl.go   = go;
   assign step      = step_ff;

endmodule

// ===== design/bhc_dp.sv =====
// ----------------------------------------------------------------------------
// bhc_dp
// Datapath: envelope and hue state, one shared 8x8 multiplier with a
// divide-by-255 stage, HSV sector mux and a bit-serial release divider.
// ----------------------------------------------------------------------------
module bhc_dp
   import bhc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ctrl_type      ctrl,
   input  logic          beat,
   input  logic [7:0]    attack_level,
   input  logic [7:0]    release_divisor,
   input  logic [7:0]    saturation,
   output pixel_type     pixel,
   output dp_status_type status
);

   logic [7:0]  bright_ff, bright_in;
   logic [8:0]  hue_ff, hue_in;
   logic [2:0]  sector_ff, sector_in;
   logic [5:0]  rem_ff, rem_in;
   logic [7:0]  frac_ff, frac_in;
   logic [15:0] prod_ff, prod_in;
   logic [7:0]  p_ff, q_ff, t_ff, tmp_ff;
   logic [7:0]  drem_ff, drem_in;
   logic [7:0]  dquo_ff, dquo_in;
   logic [2:0]  dcnt_ff, dcnt_in;

   logic [7:0]  mul_a, mul_b;
   logic [7:0]  quot255;
   logic [9:0]  frac_wide;
   logic [8:0]  sector_base;
   logic [7:0]  divisor;
   logic [8:0]  shifted;
   logic        fits;
   logic [7:0]  release_amt;
   logic        act;

   assign act = ctrl.go;

   // Envelope and hue state.
   always_comb begin
      bright_in = bright_ff;
      hue_in    = hue_ff;
      if (act && ctrl.word.op == OP_ACCEPT) begin
         if (beat) begin
            bright_in = attack_level;
         end
         hue_in = (hue_ff == HUE_LAST) ? 9'd0 : hue_ff + 9'd1;
      end else if (act && ctrl.word.op == OP_DECAY) begin
         bright_in = (bright_ff < release_amt) ? 8'd0 : bright_ff - release_amt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff <= '0;
         hue_ff    <= '0;
      end else begin
         bright_ff <= bright_in;
         hue_ff    <= hue_in;
      end
   end

   // Sector by comparing against the sector boundaries.
   always_comb begin
      sector_in = 3'd0;
      for (int k = 1; k < 6; k++) begin
         if (hue_ff >= 9'(k * SECTOR_SPAN)) begin
            sector_in = 3'(k);
         end
      end
      sector_base = 9'(sector_in) * 9'(SECTOR_SPAN);
      rem_in      = 6'(hue_ff - sector_base);
   end

   // Fraction = rem * 255 / 60, which is exactly rem * 17 / 4.
   assign frac_wide = {4'd0, rem_ff} * 10'd17;
   assign frac_in   = frac_wide[9:2];

   // Shared multiplier operands.
   always_comb begin
      unique case (ctrl.word.mul)
         MUL_VS: begin
            mul_a = bright_ff;
            mul_b = FULL_SCALE - saturation;
         end
         MUL_SF: begin
            mul_a = saturation;
            mul_b = frac_ff;
         end
         MUL_SNF: begin
            mul_a = saturation;
            mul_b = FULL_SCALE - frac_ff;
         end
         MUL_VT: begin
            mul_a = bright_ff;
            mul_b = FULL_SCALE - tmp_ff;
         end
         default: begin
            mul_a = 8'd0;
            mul_b = 8'd0;
         end
      endcase
   end

   assign prod_in = 16'(mul_a) * 16'(mul_b);
   assign quot255 = div255(prod_ff);

   // Color pipeline registers.
   always_ff @(posedge clock) begin
      if (act && ctrl.word.op == OP_SECTOR) begin
         sector_ff <= sector_in;
         rem_ff    <= rem_in;
      end
      if (act && ctrl.word.op == OP_FRAC) begin
         frac_ff <= frac_in;
      end
      if (act && ctrl.word.mul != MUL_NONE) begin
         prod_ff <= prod_in;
      end
      if (act) begin
         case (ctrl.word.dst)
            DST_P:   p_ff   <= quot255;
            DST_Q:   q_ff   <= quot255;
            DST_T:   t_ff   <= quot255;
            DST_TMP: tmp_ff <= quot255;
            default: ;
         endcase
      end
   end

   // Sector selection, with the grey path for zero saturation.
   always_comb begin
      if (saturation == 8'd0) begin
         pixel = '{blue: bright_ff, green: bright_ff, red: bright_ff};
      end else begin
         case (sector_ff)
            3'd0:    pixel = '{blue: p_ff,      green: t_ff,      red: bright_ff};
            3'd1:    pixel = '{blue: p_ff,      green: bright_ff, red: q_ff};
            3'd2:    pixel = '{blue: t_ff,      green: bright_ff, red: p_ff};
            3'd3:    pixel = '{blue: bright_ff, green: q_ff,      red: p_ff};
            3'd4:    pixel = '{blue: bright_ff, green: p_ff,      red: t_ff};
            default: pixel = '{blue: q_ff,      green: p_ff,      red: bright_ff};
         endcase
      end
   end

   // Restoring divider: brightness / release divisor, one quotient bit a step.
   assign divisor = (release_divisor == 8'd0) ? 8'd1 : release_divisor;
   assign shifted = {drem_ff, dquo_ff[7]};
   assign fits    = shifted >= {1'b0, divisor};

   always_comb begin
      drem_in = drem_ff;
      dquo_in = dquo_ff;
      dcnt_in = dcnt_ff;
      if (act && ctrl.word.op == OP_DIV_INIT) begin
         drem_in = 8'd0;
         dquo_in = bright_ff;
         dcnt_in = 3'd0;
      end else if (act && ctrl.word.op == OP_DIV_STEP) begin
         drem_in = fits ? 8'(shifted - {1'b0, divisor}) : shifted[7:0];
         dquo_in = {dquo_ff[6:0], fits};
         dcnt_in = dcnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      drem_ff <= drem_in;
      dquo_ff <= dquo_in;
      dcnt_ff <= dcnt_in;
   end

   assign status.div_last = (dcnt_ff == 3'd7);
   assign release_amt     = (dquo_ff == 8'd0) ? 8'd1 : dquo_ff;

endmodule

// ===== design/beat_envelope_hue_cycler_core.sv =====
// ----------------------------------------------------------------------------
// beat_envelope_hue_cycler_core
// Beat-triggered attack/release brightness envelope with a free-running hue,
// converted to RGB bytes by a microcoded integer HSV datapath.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_tvalid/req_tready  tdata[0] = beat
//   rsp      out        rsp_tvalid/rsp_tready  tdata = red, green, blue
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One request passes from the accept step back to idle through the accept
// step, ten microcode steps for the color math, the emit step, one divider
// setup step, eight iterations of the bit-serial release divider and the
// decay step. The result register lets the next request be accepted while
// a result waits; emit stalls only while the previous result is still held.
// Reset is synchronous and clears the envelope, the hue and the registers to
// their defaults; no request or register write is taken while it is high.
// ----------------------------------------------------------------------------
module beat_envelope_hue_cycler_core
   import bhc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request: bit 0 beat.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // Response: [7:0] red, [15:8] green, [23:16] blue.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   // Register writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   logic [7:0]    attack_ff;
   logic [7:0]    release_ff;
   logic [7:0]    sat_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   pixel_type     rsp_data_ff;
   ctrl_type      ctrl;
   step_type      step;
   dp_status_type status;
   pixel_type     pixel;
   logic          out_free;
   logic          emit_fire;

   // Register file.
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff  <= ATTACK_RESET;
         release_ff <= RELEASE_RESET;
         sat_ff     <= SAT_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_ATTACK) begin
            attack_ff <= csr_data;
         end
         if (csr_index == CSR_RELEASE) begin
            release_ff <= csr_data;
         end
         if (csr_index == CSR_SATURATION) begin
            sat_ff <= csr_data;
         end
      end
   end

   // Sequencer and datapath.
   bhc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .out_free  (out_free),
      .status    (status),
      .ctrl      (ctrl),
      .step      (step)
   );

   bhc_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .beat            (req_tdata[0]),
      .attack_level    (attack_ff),
      .release_divisor (release_ff),
      .saturation      (sat_ff),
      .pixel           (pixel),
      .status          (status)
   );

   assign req_tready = (ctrl.word.op == OP_ACCEPT) && !reset;

   // Result register.
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign emit_fire = (ctrl.word.op == OP_EMIT) && ctrl.go;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_data_ff <= pixel;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.blue, rsp_data_ff.green, rsp_data_ff.red};

   // The sequencer leaves idle only by accepting a request.
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (step == STEP_IDLE) && !(req_tvalid && req_tready) |=> (step == STEP_IDLE))
      else $error("sequencer left idle without a request");

   // An accepted request is not followed by another accept in the next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while one is in flight");

   // Zero saturation gives a grey result.
   a_grey: assert property (@(posedge clock) disable iff (reset)
      emit_fire && (sat_ff == 8'd0) |=>
         (rsp_tdata[7:0] == rsp_tdata[15:8]) && (rsp_tdata[15:8] == rsp_tdata[23:16]))
      else $error("grey path produced unequal channels");

endmodule

// ===== tb/beat_envelope_hue_cycler_core_tb.sv =====
// ----------------------------------------------------------------------------
// beat_envelope_hue_cycler_core_tb
// Self-checking testbench for the beat envelope and hue cycler. A scoreboard
// tracks the envelope, the hue and the three control registers, predicts the
// RGB pixel of every accepted request, and compares it field by field with
// the pixel the core returns. A short directed pass covers register extremes,
// grey output and the zero release divisor. Random phases with fresh register
// settings, varying beat density and random idling on both streams follow.
// ----------------------------------------------------------------------------
module beat_envelope_hue_cycler_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bhc_pkg::*;

   // Index with no register behind it; writes to it must be ignored.
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   // Cycles to let the core finish its divide and decay before a register write.
   localparam int unsigned SETTLE_CYCLES = 32;
   localparam int unsigned PRINT_LIMIT = 100;

   // Predicts the color of each frame and checks the returned pixels.
   class hue_scoreboard;
      logic [7:0] attack_reg;
      logic [7:0] release_reg;
      logic [7:0] sat_reg;
      logic [7:0] envelope;
      logic [8:0] hue;
      pixel_type  expected_pixels[$];
      int unsigned mismatches;
      int unsigned pixels_checked;
      int unsigned beat_frames;
      int unsigned grey_frames;

      function new();
         attack_reg     = ATTACK_RESET;
         release_reg    = RELEASE_RESET;
         sat_reg        = SAT_RESET;
         envelope       = 8'd0;
         hue            = 9'd0;
         mismatches     = 0;
         pixels_checked = 0;
         beat_frames    = 0;
         grey_frames    = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [7:0] data);
         case (idx)
            CSR_ATTACK:     attack_reg  = data;
            CSR_RELEASE:    release_reg = data;
            CSR_SATURATION: sat_reg     = data;
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return expected_pixels.size();
      endfunction

      // Six-sector integer HSV conversion of the current hue and envelope.
      function pixel_type hsv_pixel();
         int unsigned v, s, sector, frac, p, q, t;
         pixel_type   px;
         v = envelope;
         s = sat_reg;
         if (s == 0) begin
            px.red   = envelope;
            px.green = envelope;
            px.blue  = envelope;
            return px;
         end
         sector = hue / SECTOR_SPAN;
         frac   = (hue % SECTOR_SPAN) * FULL_SCALE / SECTOR_SPAN;
         p = v * (FULL_SCALE - s) / FULL_SCALE;
         q = v * (FULL_SCALE - s * frac / FULL_SCALE) / FULL_SCALE;
         t = v * (FULL_SCALE - s * (FULL_SCALE - frac) / FULL_SCALE) / FULL_SCALE;
         case (sector)
            0: begin px.red = v[7:0]; px.green = t[7:0]; px.blue = p[7:0]; end
            1: begin px.red = q[7:0]; px.green = v[7:0]; px.blue = p[7:0]; end
            2: begin px.red = p[7:0]; px.green = v[7:0]; px.blue = t[7:0]; end
            3: begin px.red = p[7:0]; px.green = q[7:0]; px.blue = v[7:0]; end
            4: begin px.red = t[7:0]; px.green = p[7:0]; px.blue = v[7:0]; end
            default: begin px.red = v[7:0]; px.green = p[7:0]; px.blue = q[7:0]; end
         endcase
         return px;
      endfunction

      // One accepted request: attack on a beat, step the hue, emit, then decay.
      function void note_frame(logic beat);
         logic [7:0] divisor;
         logic [7:0] drop;
         if (beat) begin
            envelope = attack_reg;
            beat_frames++;
         end
         hue = (hue == HUE_LAST) ? 9'd0 : hue + 9'd1;
         if (sat_reg == 8'd0) begin
            grey_frames++;
         end
         expected_pixels.push_back(hsv_pixel());
         // A zero divisor behaves as one; the drop is never below one.
         divisor = (release_reg == 8'd0) ? 8'd1 : release_reg;
         drop    = envelope / divisor;
         if (drop == 8'd0) begin
            drop = 8'd1;
         end
         envelope = (envelope < drop) ? 8'd0 : envelope - drop;
      endfunction

      task report_mismatch(string msg);
         if (mismatches < PRINT_LIMIT) begin
            $display("MISMATCH @%0t frame %0d: %s", $time, pixels_checked, msg);
         end
         mismatches++;
      endtask

      task check_pixel(pixel_type got);
         pixel_type want;
         if (expected_pixels.size() == 0) begin
            report_mismatch("pixel returned with no request outstanding");
            return;
         end
         want = expected_pixels.pop_front();
         pixels_checked++;
         if (got.red !== want.red) begin
            report_mismatch($sformatf("red %0d, expected %0d", got.red, want.red));
         end
         if (got.green !== want.green) begin
            report_mismatch($sformatf("green %0d, expected %0d", got.green, want.green));
         end
         if (got.blue !== want.blue) begin
            report_mismatch($sformatf("blue %0d, expected %0d", got.blue, want.blue));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [0] beat, [7:1] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;          // [7:0] red, [15:8] green, [23:16] blue
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [7:0]  csr_data = 8'd0;

   hue_scoreboard sb = new();
   bit            quiet = 1'b0;
   int unsigned   settings_applied = 0;

   beat_envelope_hue_cycler_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Both streams are observed at the clock edge where they hand off.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_frame(req_tdata[0]);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_pixel(pixel_type'(rsp_tdata));
         end
      end
   end

   function automatic int unsigned draw_gap();
      return quiet ? 0 : $urandom_range(0, 5);
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 3))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Send one frame request, optionally idling first.
   task automatic send_frame(input logic beat);
      int unsigned gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, beat};
      do @(posedge clock); while (!req_tready);
   endtask

   // Hold off requests until every pixel is back and the core is idle.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves csr_valid high; the caller lowers it after the last write.
   task automatic write_csr(input logic [1:0] idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
   endtask

   // Apply a full register setting once the core has gone idle.
   task automatic configure(input logic [7:0] attack, input logic [7:0] rel,
                            input logic [7:0] sat, input bit stray_write);
      settle();
      if (stray_write) begin
         write_csr(CSR_UNUSED, 8'($urandom_range(0, 255)));
      end
      write_csr(CSR_ATTACK, attack);
      write_csr(CSR_RELEASE, rel);
      write_csr(CSR_SATURATION, sat);
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // Receiver: stalls a random number of cycles before each pixel.
   initial begin
      int unsigned stall;
      wait (reset == 1'b0);
      forever begin
         stall = draw_gap();
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Stimulus.
   initial begin
      int unsigned beat_pct;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: one beat, then the release tail.
      send_frame(1'b1);
      repeat (3) send_frame(1'b0);

      // Grey output at full attack, divisor of one empties the envelope.
      configure(8'hFF, 8'd1, 8'h00, 1'b0);
      send_frame(1'b1);
      repeat (2) send_frame(1'b0);

      // Zero release divisor behaves as a divisor of one.
      configure(8'hFF, 8'd0, 8'h80, 1'b0);
      send_frame(1'b1);
      send_frame(1'b0);

      // Zero attack with the slowest release.
      configure(8'h00, 8'hFF, 8'hFF, 1'b0);
      send_frame(1'b1);
      send_frame(1'b0);

      // A write to the unused index must leave every register alone.
      configure(8'hFF, 8'hFF, 8'd1, 1'b1);
      send_frame(1'b1);
      repeat (2) send_frame(1'b0);

      configure(8'hC3, 8'd2, 8'h80, 1'b0);
      send_frame(1'b1);
      repeat (3) send_frame(1'b0);

      // Random phases, two of them without any idling.
      for (int ph = 0; ph < 6; ph++) begin
         quiet = (ph == 1 || ph == 4);
         configure(pick_byte(), pick_byte(), pick_byte(), $urandom_range(0, 2) == 0);
         case (ph % 3)
            0:       beat_pct = 5;
            1:       beat_pct = 25;
            default: beat_pct = 60;
         endcase
         repeat (92) send_frame($urandom_range(0, 99) < beat_pct);
      end

      quiet = 1'b0;
      settle();
      $display("Checked %0d frames, %0d on a beat and %0d grey, across %0d register settings.",
               sb.pixels_checked, sb.beat_frames, sb.grey_frames, settings_applied);
      $display("Both streams idled at random, with idle-free stretches and drains.");
      if (sb.mismatches == 0) begin
         $display("beat_envelope_hue_cycler_core_tb: done, clean");
      end else begin
         $display("beat_envelope_hue_cycler_core_tb: done, errors");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #2ms;
      $display("Timeout with %0d pixels outstanding.", sb.pending());
      $display("beat_envelope_hue_cycler_core_tb: done, errors");
      $finish;
   end

endmodule
